/* src/sfcr_pkg.sv */
`timescale 1ns / 1ps

package sfcr_pkg;

   localparam int DEFAULT_DEPTH = 4096;
   localparam int HDR_BYTES = 16;
   localparam int SUM_HDR_BYTES = 14;
   localparam int MAGIC_BYTES_N = 4;
   localparam logic [15:0] POS_MAX = 16'hFFFF;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPT_JSON = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEPT_CBOR = 1'b1;

   localparam logic [7:0] ENC_JSON = 8'h01;
   localparam logic [7:0] ENC_CBOR = 8'h02;

   localparam logic [7:0] MAGIC_BYTES [MAGIC_BYTES_N] = '{8'h4F, 8'h54, 8'h72, 8'h6B};

   typedef enum logic [3:0] {
      ST_SEGMENT   = 4'd0,
      ST_COMPLETE  = 4'd1,
      ST_SHORT     = 4'd2,
      ST_MAGIC     = 4'd3,
      ST_ENCODING  = 4'd4,
      ST_CHECKSUM  = 4'd5,
      ST_DUPLICATE = 4'd6,
      ST_ORDER     = 4'd7,
      ST_REFUSED   = 4'd8,
      ST_OVERFLOW  = 4'd9
   } status_type;

   typedef struct packed {
      logic        func;
      logic [7:0]  data_byte;
      logic        end_of_datagram;
      logic [11:0] read_index;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  encoding;
      logic [15:0] sequence_res;
      logic [31:0] offset_res;
      logic        last_res;
      logic [14:0] length_res;
      logic [12:0] message_length;
      logic [7:0]  read_data;
   } rsp_type;

   typedef struct packed {
      logic has_result;
      logic is_read;
      logic read_ok;
      logic mem_write;
   } frame_ctl_type;

endpackage

/* src/sfcr_store.sv */
`timescale 1ns / 1ps

module sfcr_store #(
   parameter int REASM_DEPTH = sfcr_pkg::DEFAULT_DEPTH,
   localparam int ADDR_W = $clog2(2 * REASM_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [2 * REASM_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sfcr_frame.sv */
`timescale 1ns / 1ps

module sfcr_frame #(
   parameter int REASM_DEPTH = sfcr_pkg::DEFAULT_DEPTH,
   localparam int ADDR_W = $clog2(2 * REASM_DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sfcr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic                                csr_wdata,
   input  logic                                step,
   input  sfcr_pkg::req_type                   item,
   output sfcr_pkg::frame_ctl_type             ctl,
   output sfcr_pkg::rsp_type                   result,
   output logic [ADDR_W-1:0]                   wr_addr,
   output logic [ADDR_W-1:0]                   rd_addr
);

   import sfcr_pkg::*;

   localparam int LEN_W = $clog2(REASM_DEPTH + 1);
   localparam int SUM_W = (LEN_W > 16 ? LEN_W : 16) + 1;
   localparam int FIN_W = (LEN_W > 15 ? LEN_W : 15) + 1;

   logic [15:0]      pos_ff, pos_in;
   logic [7:0]       hdr_ff [HDR_BYTES];
   logic [7:0]       hdr_in [HDR_BYTES];
   logic             magic_ff, magic_in;
   logic [7:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic             bank_ff, bank_in;
   logic [LEN_W-1:0] asm_ff, asm_in;
   logic [15:0]      prev_seq_ff, prev_seq_in;
   logic             prev_valid_ff, prev_valid_in;
   logic             json_ff, json_in, cbor_ff, cbor_in;

   logic             is_hdr, in_pay, sum_en, magic_view;
   logic [15:0]      pay_idx, pos_sat;
   logic [7:0]       lo_view, hi_view;
   logic [7:0]       enc;
   logic [15:0]      seq, cks;
   logic [31:0]      off;
   logic             last;
   logic [14:0]      len;
   logic             append, restart, wr_ok, wr_bank;
   logic [LEN_W-1:0] base;
   logic [SUM_W-1:0] wr_sum;
   logic [FIN_W-1:0] fin_total;
   logic             short_hdr, short_pay, over, dup, acc_ok, verdict, data_step;

   // Header bytes as they stand once the current word is taken in.
   always_comb begin
      hdr_in = hdr_ff;
      if (is_hdr && data_step) begin
         hdr_in[pos_ff[3:0]] = item.data_byte;
      end
   end

   assign is_hdr    = pos_ff < 16'(HDR_BYTES);
   assign data_step = step && !item.func;
   assign pos_sat   = (pos_ff != POS_MAX) ? pos_ff + 16'd1 : pos_ff;
   assign pay_idx   = pos_ff - 16'(HDR_BYTES);

   logic [7:0] hv [HDR_BYTES];
   always_comb begin
      hv = hdr_ff;
      if (is_hdr) begin
         hv[pos_ff[3:0]] = item.data_byte;
      end
   end

   assign enc  = hv[5];
   assign seq  = {hv[6], hv[7]};
   assign off  = {hv[8], hv[9], hv[10], hv[11]};
   assign last = hv[12][7];
   assign len  = {hv[12][6:0], hv[13]};
   assign cks  = {hv[14], hv[15]};

   assign in_pay = !is_hdr && (pay_idx < {1'b0, len});
   assign sum_en = (is_hdr && (pos_ff < 16'(SUM_HDR_BYTES))) || in_pay;
   assign lo_view = sum_en ? lo_ff + item.data_byte : lo_ff;
   assign hi_view = sum_en ? hi_ff + lo_view : hi_ff;
   assign magic_view = magic_ff &&
      !((pos_ff < 16'(MAGIC_BYTES_N)) && (item.data_byte != MAGIC_BYTES[pos_ff[1:0]]));

   assign append  = (off == 32'(asm_ff)) && (asm_ff != '0);
   assign restart = (off == 32'd0);
   assign base    = append ? asm_ff : '0;
   assign wr_sum  = SUM_W'(base) + SUM_W'(pay_idx);
   assign wr_ok   = wr_sum < SUM_W'(REASM_DEPTH);
   assign wr_bank = append ? bank_ff : ~bank_ff;
   assign wr_addr = (wr_bank ? ADDR_W'(REASM_DEPTH) : '0) + ADDR_W'(wr_sum);
   assign rd_addr = (bank_ff ? ADDR_W'(REASM_DEPTH) : '0) + ADDR_W'(item.read_index);

   assign ctl.has_result = item.func || item.end_of_datagram;
   assign ctl.is_read    = item.func;
   assign ctl.read_ok    = 32'(item.read_index) < 32'(REASM_DEPTH);
   assign ctl.mem_write  = !item.func && in_pay && (append || restart) && wr_ok;

   assign fin_total = FIN_W'(base) + FIN_W'(len);
   assign over      = fin_total > FIN_W'(REASM_DEPTH);
   assign short_hdr = pos_sat < 16'(HDR_BYTES);
   assign short_pay = {1'b0, pos_sat} < (17'(HDR_BYTES) + 17'(len));
   assign dup       = prev_valid_ff && (seq == prev_seq_ff);

   always_comb begin
      result = '0;
      acc_ok = 1'b0;
      if (!item.func) begin
         if (short_hdr) begin
            result.status = ST_SHORT;
         end else begin
            result.encoding     = enc;
            result.sequence_res = seq;
            result.offset_res   = off;
            result.last_res     = last;
            result.length_res   = len;
            if (!magic_view) begin
               result.status = ST_MAGIC;
            end else if (enc != ENC_JSON && enc != ENC_CBOR) begin
               result.status = ST_ENCODING;
            end else if (short_pay) begin
               result.status = ST_SHORT;
            end else if ({hi_view, lo_view} != cks) begin
               result.status = ST_CHECKSUM;
            end else if (dup) begin
               result.status = ST_DUPLICATE;
            end else begin
               acc_ok = 1'b1;
               if (!append && !restart) begin
                  result.status = ST_ORDER;
               end else if (over) begin
                  result.status = ST_OVERFLOW;
               end else if (!last) begin
                  result.status = ST_SEGMENT;
               end else if ((enc == ENC_JSON && json_ff) || (enc == ENC_CBOR && cbor_ff)) begin
                  result.status         = ST_COMPLETE;
                  result.message_length = 13'(fin_total);
               end else begin
                  result.status = ST_REFUSED;
               end
            end
         end
      end
   end

   assign verdict = data_step && item.end_of_datagram;

   always_comb begin
      pos_in        = pos_ff;
      magic_in      = magic_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      bank_in       = bank_ff;
      asm_in        = asm_ff;
      prev_seq_in   = prev_seq_ff;
      prev_valid_in = prev_valid_ff;
      json_in       = json_ff;
      cbor_in       = cbor_ff;
      if (data_step) begin
         if (item.end_of_datagram) begin
            pos_in   = '0;
            magic_in = 1'b1;
            lo_in    = '0;
            hi_in    = '0;
         end else begin
            pos_in   = pos_sat;
            magic_in = magic_view;
            lo_in    = lo_view;
            hi_in    = hi_view;
         end
      end
      if (verdict && acc_ok) begin
         prev_seq_in   = seq;
         prev_valid_in = 1'b1;
         if ((!append && !restart) || over || last) begin
            asm_in = '0;
         end else begin
            asm_in = LEN_W'(fin_total);
         end
         if (!append && restart && !over) begin
            bank_in = ~bank_ff;
         end
      end
      if (csr_we) begin
         case (csr_index)
            CSR_ACCEPT_JSON: json_in = csr_wdata;
            CSR_ACCEPT_CBOR: cbor_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      if (reset) begin
         pos_ff        <= '0;
         magic_ff      <= 1'b1;
         lo_ff         <= '0;
         hi_ff         <= '0;
         bank_ff       <= 1'b0;
         asm_ff        <= '0;
         prev_seq_ff   <= '0;
         prev_valid_ff <= 1'b0;
         json_ff       <= 1'b1;
         cbor_ff       <= 1'b1;
      end else begin
         pos_ff        <= pos_in;
         magic_ff      <= magic_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         bank_ff       <= bank_in;
         asm_ff        <= asm_in;
         prev_seq_ff   <= prev_seq_in;
         prev_valid_ff <= prev_valid_in;
         json_ff       <= json_in;
         cbor_ff       <= cbor_in;
      end
   end

endmodule

/* src/segment_frame_check_reassembler.sv */
`timescale 1ns / 1ps

// Checks framed datagrams that arrive one byte per word and reassembles their
// payloads into a two-bank message store of REASM_DEPTH bytes per bank. One
// word is accepted every cycle unless a result waits on rsp_ready; each word
// passes an input register, one pass of header, checksum and ordering logic,
// and a result register. Each stored payload byte costs one write to the bank
// memory and each in-range read word one registered read from it; the banks
// need no clearing after reset.
module segment_frame_check_reassembler #(
   parameter int REASM_DEPTH = sfcr_pkg::DEFAULT_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  sfcr_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output sfcr_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [sfcr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                             csr_wdata
);

   import sfcr_pkg::*;

   localparam int ADDR_W = $clog2(2 * REASM_DEPTH);

   logic          s1_valid_ff, s1_valid_in;
   req_type       s1_item_ff, s1_item_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          show_ff, show_in;
   frame_ctl_type ctl;
   rsp_type       result;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]    rd_data;
   logic          out_free, s1_go, load_rsp;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && (!ctl.has_result || out_free);
   assign req_ready = !s1_valid_ff || s1_go;
   assign load_rsp  = s1_go && ctl.has_result;

   sfcr_frame #(.REASM_DEPTH(REASM_DEPTH)) u_frame (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (s1_go),
      .item      (s1_item_ff),
      .ctl       (ctl),
      .result    (result),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr)
   );

   sfcr_store #(.REASM_DEPTH(REASM_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (s1_go && ctl.mem_write),
      .wr_addr (wr_addr),
      .wr_data (s1_item_ff.data_byte),
      .rd_en   (s1_go && ctl.is_read && ctl.read_ok),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      show_in      = show_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_item_in  = req_data;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
         show_in      = ctl.is_read && ctl.read_ok;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      rsp_ff     <= rsp_in;
      show_ff    <= show_in;
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.read_data = show_ff ? rd_data : 8'd0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
